// ===== rtl/core/flph_pkg.sv =====
// ----------------------------------------------------------------------------
// flph_pkg
// Shared types and constants of the FNV-1a linear probe hash table.
// ----------------------------------------------------------------------------
package flph_pkg;

    localparam int unsigned CAPACITY_DEF   = 64;
    localparam int unsigned KEY_BYTES_DEF  = 8;
    localparam int unsigned VALUE_BITS_DEF = 32;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_SET    = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    // request passed from the front end to the back end
    typedef struct packed {
        t_action     action;
        logic [63:0] key;
        logic [3:0]  len;
        logic [63:0] value;
        logic [63:0] hash;
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_be_state;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MUL_LO,
        FS_MUL_HI
    } t_fe_state;

endpackage

// ===== rtl/core/fnv1a_linear_probe_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// fnv1a_linear_probe_hash_table_core
// Key-value table, FNV-1a home slot, linear probing, fixed capacity.
// ----------------------------------------------------------------------------
// Requests enter through a queue-like port: i_push with o_full low accepts a
// transaction carrying action, key bytes, key length and new value. Results
// leave the same way: while o_empty is low, found, value_out and status are
// shown and i_pop takes them.
// The front end hashes the key one byte at a time on a split 64-bit
// multiply and hands the request through a two-entry queue to the back
// end, which probes slots one at a time, each through a read and a check
// state on the registered slot memory; front and back overlap. Clear goes
// straight to the result without probing. Reset empties every slot at once
// through the used flags. When the receiver does not pop, the back end
// holds its result and the queue and front end fill, then o_full stays high.
// ----------------------------------------------------------------------------
module fnv1a_linear_probe_hash_table_core #(
    parameter int unsigned CAPACITY   = flph_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_BYTES  = flph_pkg::KEY_BYTES_DEF,
    parameter int unsigned VALUE_BITS = flph_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_key_bytes,
    input  logic [3:0]  i_key_length,
    input  logic [31:0] i_new_value,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_found,
    output logic [31:0] o_value_out,
    output logic        o_status
);
    import flph_pkg::*;

    t_req w_fe_req, w_q_req;
    logic w_fe_valid, w_fe_ready, w_q_valid, w_q_ready;

    // front end
    flph_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full),
        .i_action(i_action), .i_key_bytes(i_key_bytes),
        .i_key_length(i_key_length), .i_new_value(i_new_value),
        .o_valid(w_fe_valid), .i_ready(w_fe_ready), .o_req(w_fe_req)
    );

    // decoupling queue
    flph_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fe_valid), .o_ready(w_fe_ready), .i_req(w_fe_req),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_req(w_q_req)
    );

    // back end
    flph_back #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_req(w_q_req),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_found(o_found), .o_value_out(o_value_out), .o_status(o_status)
    );

endmodule

// ===== rtl/core/flph_front.sv =====
// ----------------------------------------------------------------------------
// flph_front
// Accepts requests, normalises the key and hashes it with FNV-1a one byte at
// a time, the prime multiply split into a shift by 40 and a x 0x1b3 step.
// ----------------------------------------------------------------------------
module flph_front #(
    parameter int unsigned KEY_BYTES  = flph_pkg::KEY_BYTES_DEF,
    parameter int unsigned VALUE_BITS = flph_pkg::VALUE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic [1:0]      i_action,
    input  logic [63:0]     i_key_bytes,
    input  logic [3:0]      i_key_length,
    input  logic [31:0]     i_new_value,
    output logic            o_valid,
    input  logic            i_ready,
    output flph_pkg::t_req  o_req
);
    import flph_pkg::*;

    t_fe_state   r_state, n_state;
    t_req        r_req;
    logic [3:0]  r_idx;
    logic [63:0] r_h;
    logic [63:0] r_x;
    logic        r_out_valid;

    logic [3:0]  w_len;
    logic [63:0] w_mask;
    logic [63:0] w_val_mask;
    logic [7:0]  w_byte;

    // saturate length and mask stray key bits
    always_comb begin
        w_len = (i_key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_key_length;
        w_mask = (w_len == 4'd0) ? 64'd0 : (64'hffffffffffffffff >> (7'd64 - {w_len, 3'b000}));
        w_val_mask = 64'hffffffffffffffff >> (64 - VALUE_BITS);
        w_byte = r_req.key[{r_idx[2:0], 3'b000} +: 8];
    end

    assign o_full  = (r_state != FS_IDLE) || r_out_valid;
    assign o_valid = r_out_valid;
    assign o_req   = r_req;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE:   if (i_push && !o_full) n_state = FS_MUL_LO;
            FS_MUL_LO: if (r_idx != r_req.len) n_state = FS_MUL_HI;
                       else n_state = FS_IDLE;
            FS_MUL_HI: n_state = FS_MUL_LO;
            default:   n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == FS_MUL_LO && r_idx == r_req.len)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready)
                r_out_valid <= 1'b0;
        end
    end

    // hash datapath: h = (h ^ b) * prime, prime = 2^40 + 0x1b3
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            FS_IDLE: begin
                if (i_push && !o_full) begin
                    r_req.action <= t_action'(i_action);
                    r_req.key    <= i_key_bytes & w_mask;
                    r_req.len    <= w_len;
                    r_req.value  <= {32'd0, i_new_value} & w_val_mask;
                    r_h          <= FNV_BASIS;
                    r_idx        <= 4'd0;
                end
            end
            FS_MUL_LO: begin
                if (r_idx == r_req.len) begin
                    r_req.hash <= r_h;
                end else begin
                    r_x <= r_h ^ {56'd0, w_byte};
                    r_h <= (r_h ^ {56'd0, w_byte}) << 40;
                end
            end
            FS_MUL_HI: begin
                r_h   <= r_h + 64'(r_x * 64'h1b3);
                r_idx <= r_idx + 4'd1;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/flph_queue.sv =====
// ----------------------------------------------------------------------------
// flph_queue
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module flph_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  flph_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output flph_pkg::t_req o_req
);
    import flph_pkg::*;

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_mem[r_rp];
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_req;
    end

endmodule

// ===== rtl/core/flph_back.sv =====
// ----------------------------------------------------------------------------
// flph_back
// Walks the probe chain through the slot memory, one slot per read and check
// state pair, and carries out lookup, set and clear.
// ----------------------------------------------------------------------------
module flph_back #(
    parameter int unsigned CAPACITY   = flph_pkg::CAPACITY_DEF,
    parameter int unsigned VALUE_BITS = flph_pkg::VALUE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  flph_pkg::t_req i_req,
    output logic           o_empty,
    input  logic           i_pop,
    output logic           o_found,
    output logic [31:0]    o_value_out,
    output logic           o_status
);
    import flph_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY / 2 + 1);

    // slot memory; used bits are flip-flops so clear is immediate
    logic [CAPACITY-1:0]  r_used;
    logic [63:0]          m_key [CAPACITY];
    logic [3:0]           m_len [CAPACITY];
    logic [VALUE_BITS-1:0] m_val [CAPACITY];

    t_be_state   r_state, n_state;
    t_req        r_req;
    logic [AW-1:0] r_slot;
    logic [AW:0]   r_n;
    logic [CW-1:0] r_count;
    logic [63:0]   r_rd_key;
    logic [3:0]    r_rd_len;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic          r_rd_used;
    logic          r_found;
    logic [31:0]   r_vout;
    logic          r_status;
    logic          r_out_valid;

    logic w_take, w_hit, w_free, w_end;

    assign o_ready     = (r_state == ST_IDLE) && !r_out_valid;
    assign w_take      = i_valid && o_ready;
    assign o_empty     = !r_out_valid;
    assign o_found     = r_found;
    assign o_value_out = r_vout;
    assign o_status    = r_status;

    assign w_free = !r_rd_used;
    assign w_hit  = r_rd_used && (r_rd_len == r_req.len) && (r_rd_key == r_req.key);
    assign w_end  = (r_n == (AW+1)'(CAPACITY - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (i_req.action == ACT_LOOKUP || i_req.action == ACT_SET)
                        n_state = ST_READ;
                    else
                        n_state = ST_DONE;
                end
            end
            ST_READ:  n_state = ST_CHECK;
            ST_CHECK: if (w_hit || w_free || w_end) n_state = ST_DONE;
                      else n_state = ST_READ;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_pop)
                r_out_valid <= 1'b0;
            if (w_take && i_req.action == ACT_CLEAR) begin
                r_used  <= '0;
                r_count <= '0;
            end
            if (r_state == ST_CHECK && r_req.action == ACT_SET && !w_hit && w_free
                && (r_count < CW'(CAPACITY / 2))) begin
                r_used[r_slot] <= 1'b1;
                r_count        <= r_count + CW'(1);
            end
        end
    end

    // slot reads are registered
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd_key  <= m_key[r_slot];
            r_rd_len  <= m_len[r_slot];
            r_rd_val  <= m_val[r_slot];
            r_rd_used <= r_used[r_slot];
        end
    end

    // slot writes
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHECK && r_req.action == ACT_SET) begin
            if (w_hit) begin
                m_val[r_slot] <= r_req.value[VALUE_BITS-1:0];
            end else if (w_free && (r_count < CW'(CAPACITY / 2))) begin
                m_key[r_slot] <= r_req.key;
                m_len[r_slot] <= r_req.len;
                m_val[r_slot] <= r_req.value[VALUE_BITS-1:0];
            end
        end
    end

    // probe walk and result
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    r_req    <= i_req;
                    r_slot   <= i_req.hash[AW-1:0];
                    r_n      <= '0;
                    r_found  <= 1'b0;
                    r_vout   <= 32'd0;
                    r_status <= 1'b0;
                end
            end
            ST_CHECK: begin
                if (w_hit) begin
                    r_found <= 1'b1;
                    r_vout  <= 32'(64'(r_rd_val));
                end else if (r_req.action == ACT_SET && (!w_free
                             || r_count >= CW'(CAPACITY / 2)) && (w_free || w_end)) begin
                    r_status <= 1'b1;
                end
                if (!w_hit && !w_free && !w_end) begin
                    r_slot <= r_slot + AW'(1);
                    r_n    <= r_n + (AW+1)'(1);
                end
            end
            default: ;
        endcase
    end

endmodule
